// ----- rtl/density_peak_graph_clustering_defines.svh -----
// ----------------------------------------------------------------------------
// density peak graph clustering assertion macros
// shared assertion helpers, clocked on clk_i; DPGC_ASSERT is gated by rst_ni
// ----------------------------------------------------------------------------
`ifndef DENSITY_PEAK_GRAPH_CLUSTERING_DEFINES_SVH
`define DENSITY_PEAK_GRAPH_CLUSTERING_DEFINES_SVH

`ifndef ASSERT_OFF
`define DPGC_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error("dpgc check failed");
`define DPGC_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk_i) prop) else $error("dpgc reset check failed");
`else
`define DPGC_ASSERT(name, prop)
`define DPGC_ASSERT_RST(name, prop)
`endif

`endif

// ----- rtl/dpgc_pkg.sv -----
// ----------------------------------------------------------------------------
// dpgc_pkg
// shared codes, constants and controller/datapath interface types
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dpgc_pkg;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_EDGE    = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam logic REG_NODE_COUNT   = 1'b0;
  localparam logic REG_CLOSE_CUTOFF = 1'b1;

  localparam logic [6:0] NODE_COUNT_RST = 7'd64;
  localparam logic [5:0] CUTOFF_RST     = 6'd3;
  localparam logic [6:0] FAR_AWAY       = 7'd127;

  typedef struct packed {
    logic load_edge;
    logic clear_adj;
    logic adj_rd_a;
    logic adj_wr_a;
    logic adj_wr_b;
    logic start;
    logic bfs_init;
    logic lvl_start;
    logic adj_rd;
    logic lvl_upd;
    logic hop_wr;
    logic dens_wr;
    logic ch_init;
    logic ch_rd;
    logic ch_wr;
    logic head_wr;
    logic pr_rd_t;
    logic pr_wr;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic front_zero;
    logic edge_ok;
  } status_t;

endpackage

// ----- rtl/density_peak_graph_clustering.sv -----
// edge add and clear: one request at a time.
// compute: per source a search level by level, then a pass to store the row,
// then peak selection, n head tests, n chain passes over n nodes each,
// and then the results; the single adjacency read port sets the search cost.
// reset clears the graph (row valid bits), control state and the registers
// to node_count 64 and close_cutoff 3; no clearing pass is needed.
// ----------------------------------------------------------------------------
// density_peak_graph_clustering
// hop-distance density peak clustering of an undirected graph
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "density_peak_graph_clustering_defines.svh"

module density_peak_graph_clustering #(
  parameter int MAX_NODES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [6:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] operation_i,
  input  logic [6:0] end_a_i,
  input  logic [6:0] end_b_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [6:0] node_id_o,
  output logic [6:0] cluster_id_o,
  output logic [6:0] head_node_o,
  output logic [5:0] node_density_o,
  output logic [6:0] dist_to_denser_o,
  output logic [6:0] nearest_denser_o,
  output logic [6:0] head_count_o,
  output logic       last_o
);
  import dpgc_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  cmd_t          cmd;
  status_t       status;
  logic [CW-1:0] n_nodes;
  logic [IW-1:0] node_idx, peer_idx;

  dpgc_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .n_i         (n_nodes),
    .in_ready_o  (in_ready_o),
    .cmd_o       (cmd),
    .node_idx_o  (node_idx),
    .peer_idx_o  (peer_idx)
  );

  dpgc_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .end_a_i          (end_a_i),
    .end_b_i          (end_b_i),
    .cmd_i            (cmd),
    .node_idx_i       (node_idx),
    .peer_idx_i       (peer_idx),
    .out_ready_i      (out_ready_i),
    .status_o         (status),
    .n_o              (n_nodes),
    .out_valid_o      (out_valid_o),
    .node_id_o        (node_id_o),
    .cluster_id_o     (cluster_id_o),
    .head_node_o      (head_node_o),
    .node_density_o   (node_density_o),
    .dist_to_denser_o (dist_to_denser_o),
    .nearest_denser_o (nearest_denser_o),
    .head_count_o     (head_count_o),
    .last_o           (last_o)
  );

  `DPGC_ASSERT(a_out_blocks_in, out_valid_o |-> !in_ready_o)
  `DPGC_ASSERT(a_compute_busy, (in_valid_i && in_ready_o && (operation_i == OP_COMPUTE)) |=> !in_ready_o)
  `DPGC_ASSERT(a_last_frees_in, (out_valid_o && out_ready_i && last_o) |=> in_ready_o)
  `DPGC_ASSERT(a_cluster_head_pair, out_valid_o |-> ((cluster_id_o == 7'd0) == (head_node_o == 7'd0)))
  `DPGC_ASSERT_RST(a_reset_idle, !rst_ni |=> !out_valid_o)

endmodule

// ----- rtl/dpgc_ctrl.sv -----
// ----------------------------------------------------------------------------
// dpgc_ctrl
// sequencer for edge updates, per-source search, peak selection and output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpgc_ctrl #(
  parameter int MAX_NODES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [1:0]                       operation_i,
  input  logic                             out_ready_i,
  input  dpgc_pkg::status_t                status_i,
  input  logic [$clog2(MAX_NODES+1)-1:0]   n_i,
  output logic                             in_ready_o,
  output dpgc_pkg::cmd_t                   cmd_o,
  output logic [$clog2(MAX_NODES)-1:0]     node_idx_o,
  output logic [$clog2(MAX_NODES)-1:0]     peer_idx_o
);
  import dpgc_pkg::*;

  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int IW = $clog2(MAX_NODES);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_EA     = 5'd1;
  localparam logic [4:0] S_EWA    = 5'd2;
  localparam logic [4:0] S_EWB    = 5'd3;
  localparam logic [4:0] S_BINIT  = 5'd4;
  localparam logic [4:0] S_LSTART = 5'd5;
  localparam logic [4:0] S_LSWEEP = 5'd6;
  localparam logic [4:0] S_LEND   = 5'd7;
  localparam logic [4:0] S_LUPD   = 5'd8;
  localparam logic [4:0] S_LCHK   = 5'd9;
  localparam logic [4:0] S_WSWEEP = 5'd10;
  localparam logic [4:0] S_WDENS  = 5'd11;
  localparam logic [4:0] S_CRI    = 5'd12;
  localparam logic [4:0] S_CLI    = 5'd13;
  localparam logic [4:0] S_CSWEEP = 5'd14;
  localparam logic [4:0] S_CEND   = 5'd15;
  localparam logic [4:0] S_CWR    = 5'd16;
  localparam logic [4:0] S_HRD    = 5'd17;
  localparam logic [4:0] S_HWR    = 5'd18;
  localparam logic [4:0] S_PR1    = 5'd19;
  localparam logic [4:0] S_PR2    = 5'd20;
  localparam logic [4:0] S_PW     = 5'd21;
  localparam logic [4:0] S_ORD    = 5'd22;
  localparam logic [4:0] S_OLD    = 5'd23;
  localparam logic [4:0] S_OWAIT  = 5'd24;

  logic [4:0]    state_q, state_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, p_q, p_d;
  logic [CW-1:0] n_m1;
  logic          i_last, j_last, p_last;

  assign n_m1   = n_i - CW'(1);
  assign i_last = (i_q == n_m1);
  assign j_last = (j_q == n_m1);
  assign p_last = (p_q == n_m1);

  assign node_idx_o = i_q[IW-1:0];
  assign peer_idx_o = j_q[IW-1:0];

  always_comb begin
    state_d    = state_q;
    i_d        = i_q;
    j_d        = j_q;
    p_d        = p_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (operation_i)
            OP_CLEAR: cmd_o.clear_adj = 1'b1;
            OP_EDGE: begin
              if (status_i.edge_ok) begin
                cmd_o.load_edge = 1'b1;
                state_d         = S_EA;
              end
            end
            OP_COMPUTE: begin
              cmd_o.start = 1'b1;
              i_d         = '0;
              state_d     = S_BINIT;
            end
            default: ;
          endcase
        end
      end
      S_EA: begin
        cmd_o.adj_rd_a = 1'b1;
        state_d        = S_EWA;
      end
      S_EWA: begin
        cmd_o.adj_wr_a = 1'b1;
        state_d        = S_EWB;
      end
      S_EWB: begin
        cmd_o.adj_wr_b = 1'b1;
        state_d        = S_IDLE;
      end
      S_BINIT: begin
        cmd_o.bfs_init = 1'b1;
        state_d        = S_LSTART;
      end
      S_LSTART: begin
        cmd_o.lvl_start = 1'b1;
        j_d             = '0;
        state_d         = S_LSWEEP;
      end
      S_LSWEEP: begin
        cmd_o.adj_rd = 1'b1;
        if (j_last) state_d = S_LEND;
        else j_d = j_q + CW'(1);
      end
      S_LEND: state_d = S_LUPD;
      S_LUPD: begin
        cmd_o.lvl_upd = 1'b1;
        state_d       = S_LCHK;
      end
      S_LCHK: begin
        if (status_i.front_zero) begin
          j_d     = '0;
          state_d = S_WSWEEP;
        end else begin
          state_d = S_LSTART;
        end
      end
      S_WSWEEP: begin
        cmd_o.hop_wr = 1'b1;
        if (j_last) state_d = S_WDENS;
        else j_d = j_q + CW'(1);
      end
      S_WDENS: begin
        cmd_o.dens_wr = 1'b1;
        if (i_last) begin
          i_d     = '0;
          state_d = S_CRI;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_BINIT;
        end
      end
      S_CRI: state_d = S_CLI;
      S_CLI: begin
        cmd_o.ch_init = 1'b1;
        j_d           = '0;
        state_d       = S_CSWEEP;
      end
      S_CSWEEP: begin
        cmd_o.ch_rd = 1'b1;
        if (j_last) state_d = S_CEND;
        else j_d = j_q + CW'(1);
      end
      S_CEND: state_d = S_CWR;
      S_CWR: begin
        cmd_o.ch_wr = 1'b1;
        if (i_last) begin
          i_d     = '0;
          state_d = S_HRD;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_CRI;
        end
      end
      S_HRD: state_d = S_HWR;
      S_HWR: begin
        cmd_o.head_wr = 1'b1;
        if (i_last) begin
          i_d     = '0;
          p_d     = '0;
          state_d = S_PR1;
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_HRD;
        end
      end
      S_PR1: state_d = S_PR2;
      S_PR2: begin
        cmd_o.pr_rd_t = 1'b1;
        state_d       = S_PW;
      end
      S_PW: begin
        cmd_o.pr_wr = 1'b1;
        if (i_last) begin
          i_d = '0;
          if (p_last) begin
            state_d = S_ORD;
          end else begin
            p_d     = p_q + CW'(1);
            state_d = S_PR1;
          end
        end else begin
          i_d     = i_q + CW'(1);
          state_d = S_PR1;
        end
      end
      S_ORD: state_d = S_OLD;
      S_OLD: begin
        cmd_o.out_ld = 1'b1;
        state_d      = S_OWAIT;
      end
      S_OWAIT: begin
        if (out_ready_i) begin
          if (i_last) begin
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_ORD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      p_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      p_q     <= p_d;
    end
  end

endmodule

// ----- rtl/dpgc_datapath.sv -----
// ----------------------------------------------------------------------------
// dpgc_datapath
// adjacency and distance stores, search frontier, peak selection and result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dpgc_datapath #(
  parameter int MAX_NODES = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [6:0]                       cfg_data_i,
  input  logic [6:0]                       end_a_i,
  input  logic [6:0]                       end_b_i,
  input  dpgc_pkg::cmd_t                   cmd_i,
  input  logic [$clog2(MAX_NODES)-1:0]     node_idx_i,
  input  logic [$clog2(MAX_NODES)-1:0]     peer_idx_i,
  input  logic                             out_ready_i,
  output dpgc_pkg::status_t                status_o,
  output logic [$clog2(MAX_NODES+1)-1:0]   n_o,
  output logic                             out_valid_o,
  output logic [6:0]                       node_id_o,
  output logic [6:0]                       cluster_id_o,
  output logic [6:0]                       head_node_o,
  output logic [5:0]                       node_density_o,
  output logic [6:0]                       dist_to_denser_o,
  output logic [6:0]                       nearest_denser_o,
  output logic [6:0]                       head_count_o,
  output logic                             last_o
);
  import dpgc_pkg::*;

  localparam int IW        = $clog2(MAX_NODES);
  localparam int CW        = $clog2(MAX_NODES + 1);
  localparam int HW        = 2 * IW;
  localparam int HOP_DEPTH = 1 << HW;
  localparam int SW        = $clog2(127 * MAX_NODES + 1);
  localparam int PW        = 7 + CW;

  // configuration
  logic [6:0] node_count_q;
  logic [5:0] cutoff_q;
  logic [CW-1:0] n_eff;
  logic [MAX_NODES-1:0] used;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
      cutoff_q     <= CUTOFF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NODE_COUNT:   node_count_q <= cfg_data_i;
        REG_CLOSE_CUTOFF: cutoff_q     <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (node_count_q == 7'd0) n_eff = CW'(1);
    else if (node_count_q > 7'(MAX_NODES)) n_eff = CW'(MAX_NODES);
    else n_eff = CW'(node_count_q);
    for (int k = 0; k < MAX_NODES; k++) used[k] = (k < int'(n_eff));
  end

  assign n_o = n_eff;

  // edge operands
  logic [IW-1:0] a_q, b_q;
  assign status_o.edge_ok = (end_a_i != 7'd0) && (end_a_i <= 7'(MAX_NODES)) &&
                            (end_b_i != 7'd0) && (end_b_i <= 7'(MAX_NODES));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_edge) begin
      a_q <= IW'(end_a_i - 7'd1);
      b_q <= IW'(end_b_i - 7'd1);
    end
  end

  // adjacency rows with per-row valid bits
  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0] adj_vld_q;
  logic [MAX_NODES-1:0] adj_rdata_q, adj_row, adj_wdata;
  logic                 adj_rvld_q, adj_we;
  logic [IW-1:0]        adj_raddr, adj_waddr;
  logic [MAX_NODES-1:0] one_hot_lsb;

  assign one_hot_lsb = MAX_NODES'(1);

  always_comb begin
    adj_raddr = peer_idx_i;
    if (cmd_i.adj_rd_a) adj_raddr = a_q;
    if (cmd_i.adj_wr_a) adj_raddr = b_q;
  end

  assign adj_row   = adj_rdata_q & {MAX_NODES{adj_rvld_q}};
  assign adj_we    = cmd_i.adj_wr_a | cmd_i.adj_wr_b;
  assign adj_waddr = cmd_i.adj_wr_a ? a_q : b_q;
  assign adj_wdata = adj_row | (one_hot_lsb << (cmd_i.adj_wr_a ? b_q : a_q));

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    adj_rdata_q <= adj_mem[adj_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q  <= '0;
      adj_rvld_q <= 1'b0;
    end else begin
      adj_rvld_q <= adj_vld_q[adj_raddr];
      if (cmd_i.clear_adj) adj_vld_q <= '0;
      else if (adj_we) adj_vld_q[adj_waddr] <= 1'b1;
    end
  end

  // breadth-first search from one source
  logic [MAX_NODES-1:0] seen_q, front_q, next_q, lvl_new;
  logic [6:0]           level_q;
  logic                 rdv_q;
  logic [IW-1:0]        rdj_q;
  logic [6:0]           dist_row_q [MAX_NODES];
  logic [5:0]           cnt_q;

  assign lvl_new             = next_q & used & ~seen_q;
  assign status_o.front_zero = (front_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rdv_q <= 1'b0;
    else rdv_q <= cmd_i.adj_rd;
  end

  always_ff @(posedge clk_i) begin
    rdj_q <= peer_idx_i;
    if (cmd_i.bfs_init) begin
      seen_q  <= one_hot_lsb << node_idx_i;
      front_q <= one_hot_lsb << node_idx_i;
      level_q <= '0;
      cnt_q   <= '0;
      for (int k = 0; k < MAX_NODES; k++)
        dist_row_q[k] <= (k == int'(node_idx_i)) ? 7'd0 : FAR_AWAY;
    end
    if (cmd_i.lvl_start) begin
      next_q  <= '0;
      level_q <= level_q + 7'd1;
    end else if (rdv_q && front_q[rdj_q]) begin
      next_q <= next_q | adj_row;
    end
    if (cmd_i.lvl_upd) begin
      front_q <= lvl_new;
      seen_q  <= seen_q | lvl_new;
      for (int k = 0; k < MAX_NODES; k++)
        if (lvl_new[k]) dist_row_q[k] <= level_q;
    end
    if (cmd_i.hop_wr) begin
      for (int k = 0; k < MAX_NODES - 1; k++) dist_row_q[k] <= dist_row_q[k+1];
      dist_row_q[MAX_NODES-1] <= FAR_AWAY;
      if ((peer_idx_i != node_idx_i) && (dist_row_q[0] < {1'b0, cutoff_q}))
        cnt_q <= cnt_q + 6'd1;
    end
  end

  // hop distance store
  logic [6:0]    hop_mem [HOP_DEPTH];
  logic [6:0]    hop_rdata_q;
  logic [HW-1:0] hop_addr;

  assign hop_addr = {node_idx_i, peer_idx_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.hop_wr) hop_mem[hop_addr] <= dist_row_q[0];
    hop_rdata_q <= hop_mem[hop_addr];
  end

  // density store
  logic [5:0]    dens_mem [MAX_NODES];
  logic [5:0]    dens_rdata_q;
  logic [IW-1:0] dens_raddr;

  assign dens_raddr = cmd_i.ch_rd ? peer_idx_i : node_idx_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.dens_wr) dens_mem[node_idx_i] <= cnt_q;
    dens_rdata_q <= dens_mem[dens_raddr];
  end

  // nearest denser node selection
  logic          ch_v_q, found_q;
  logic [IW-1:0] ch_j_q, pick_q, far_pick_q, sel_node;
  logic [5:0]    dens_self_q, pick_dens_q;
  logic [6:0]    best_q, far_best_q, sel_dist;
  logic [SW-1:0] sum_q;
  logic [6:0]    heads_q;

  assign sel_dist = found_q ? best_q : far_best_q;
  assign sel_node = found_q ? pick_q : far_pick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ch_v_q <= 1'b0;
    else ch_v_q <= cmd_i.ch_rd;
  end

  always_ff @(posedge clk_i) begin
    ch_j_q <= peer_idx_i;
    if (cmd_i.ch_init) begin
      dens_self_q <= dens_rdata_q;
      found_q     <= 1'b0;
      best_q      <= FAR_AWAY;
      pick_q      <= node_idx_i;
      far_best_q  <= '0;
      far_pick_q  <= node_idx_i;
    end else if (ch_v_q) begin
      if (dens_self_q < dens_rdata_q) begin
        if (!found_q || (hop_rdata_q < best_q)) begin
          best_q      <= hop_rdata_q;
          pick_q      <= ch_j_q;
          pick_dens_q <= dens_rdata_q;
          found_q     <= 1'b1;
        end else if ((hop_rdata_q == best_q) && (dens_rdata_q > pick_dens_q)) begin
          pick_q      <= ch_j_q;
          pick_dens_q <= dens_rdata_q;
        end
      end
      if (hop_rdata_q > far_best_q) begin
        far_best_q <= hop_rdata_q;
        far_pick_q <= ch_j_q;
      end
    end
  end

  // denser distance and node stores
  logic [6:0]    ddist_mem [MAX_NODES];
  logic [IW-1:0] dnode_mem [MAX_NODES];
  logic [6:0]    ddist_rdata_q;
  logic [IW-1:0] dnode_rdata_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ch_wr) begin
      ddist_mem[node_idx_i] <= sel_dist;
      dnode_mem[node_idx_i] <= sel_node;
    end
    ddist_rdata_q <= ddist_mem[node_idx_i];
    dnode_rdata_q <= dnode_mem[node_idx_i];
  end

  // head test
  logic [PW-1:0] prod;
  logic          is_head;

  assign prod    = PW'(ddist_rdata_q) * PW'(n_eff);
  assign is_head = prod > PW'(sum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      sum_q   <= '0;
      heads_q <= '0;
    end else begin
      if (cmd_i.ch_wr) sum_q <= sum_q + SW'(sel_dist);
      if (cmd_i.head_wr && is_head) heads_q <= heads_q + 7'd1;
    end
  end

  // cluster and head stores with chain propagation
  logic [6:0]    cl_mem [MAX_NODES];
  logic [6:0]    hd_mem [MAX_NODES];
  logic [6:0]    cl_rdata_q, hd_rdata_q, cl_wdata, hd_wdata, ci_q;
  logic [IW-1:0] cl_raddr, t_q;
  logic          cl_we, pr_take;

  assign cl_raddr = cmd_i.pr_rd_t ? dnode_rdata_q : node_idx_i;
  assign pr_take  = (ci_q == 7'd0) && (CW'(t_q) < n_eff) && (cl_rdata_q != 7'd0);
  assign cl_we    = cmd_i.head_wr | (cmd_i.pr_wr & pr_take);

  always_comb begin
    if (cmd_i.head_wr) begin
      cl_wdata = is_head ? (heads_q + 7'd1) : 7'd0;
      hd_wdata = is_head ? (7'(node_idx_i) + 7'd1) : 7'd0;
    end else begin
      cl_wdata = cl_rdata_q;
      hd_wdata = hd_rdata_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cl_we) begin
      cl_mem[node_idx_i] <= cl_wdata;
      hd_mem[node_idx_i] <= hd_wdata;
    end
    cl_rdata_q <= cl_mem[cl_raddr];
    hd_rdata_q <= hd_mem[cl_raddr];
    if (cmd_i.pr_rd_t) begin
      ci_q <= cl_rdata_q;
      t_q  <= dnode_rdata_q;
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_ld) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      node_id_o        <= 7'(node_idx_i) + 7'd1;
      cluster_id_o     <= cl_rdata_q;
      head_node_o      <= hd_rdata_q;
      node_density_o   <= dens_rdata_q;
      dist_to_denser_o <= ddist_rdata_q;
      nearest_denser_o <= 7'(dnode_rdata_q) + 7'd1;
      head_count_o     <= heads_q;
      last_o           <= (CW'(node_idx_i) == (n_eff - CW'(1)));
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
